/* rtl/core/pic_pkg.sv */
package pic_pkg;

    localparam int NUM_SOURCES_DEF = 32;
    localparam int PRIO_W          = 3;
    localparam int ID_W            = 5;
    localparam int ADDR_W          = 22;
    localparam int DATA_W          = 32;

    localparam logic [ADDR_W-1:0] ENABLE_ADDR    = 22'h002000;
    localparam logic [ADDR_W-1:0] THRESHOLD_ADDR = 22'h200000;
    localparam logic [ADDR_W-1:0] CLAIM_ADDR     = 22'h200004;

    typedef enum logic [1:0] {
        KIND_RAISE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_WRITE = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [ID_W-1:0]     source;
        logic [ADDR_W-1:0]   address;
        logic [DATA_W-1:0]   write_data;
    } item_t;

endpackage

/* rtl/core/pic_arbiter.sv */
module pic_arbiter #(
    parameter int NUM_SOURCES = pic_pkg::NUM_SOURCES_DEF
) (
    input  logic [NUM_SOURCES-1:0]    cand,
    input  logic [pic_pkg::PRIO_W-1:0] prio [NUM_SOURCES],
    input  logic [pic_pkg::PRIO_W-1:0] threshold,
    output logic [pic_pkg::ID_W-1:0]   best_id,
    output logic                       any
);

    logic [NUM_SOURCES-1:0] lvl;
    logic [NUM_SOURCES-1:0] sel;
    logic [NUM_SOURCES-1:0] first;

    always_comb
    begin
        lvl = '0;
        sel = '0;
        for (int p = 1; p < (1 << pic_pkg::PRIO_W); p++)
        begin
            for (int i = 0; i < NUM_SOURCES; i++)
            begin
                lvl[i] = cand[i] && (prio[i] == pic_pkg::PRIO_W'(p));
            end
            if ((|lvl) && (pic_pkg::PRIO_W'(p) > threshold))
            begin
                sel = lvl;
            end
        end
    end

    assign first = sel & (~sel + {{(NUM_SOURCES-1){1'b0}}, 1'b1});
    assign any   = |sel;

    always_comb
    begin
        best_id = '0;
        for (int i = 0; i < NUM_SOURCES; i++)
        begin
            if (first[i])
            begin
                best_id = best_id | pic_pkg::ID_W'(i);
            end
        end
    end

endmodule

/* rtl/core/pic_regs.sv */
module pic_regs #(
    parameter int NUM_SOURCES = pic_pkg::NUM_SOURCES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        fire,
    input  pic_pkg::item_t              item,
    output logic [pic_pkg::DATA_W-1:0]  read_data,
    output logic                        irq_any,
    output logic [NUM_SOURCES-1:0]      pending,
    output logic [NUM_SOURCES-1:0]      in_service
);

    localparam int SrcW = $clog2(NUM_SOURCES);
    localparam logic [NUM_SOURCES-1:0] SrcMask = {{(NUM_SOURCES-1){1'b1}}, 1'b0};

    logic [pic_pkg::PRIO_W-1:0] prio_reg [NUM_SOURCES];
    logic [pic_pkg::PRIO_W-1:0] prio_next [NUM_SOURCES];
    logic [NUM_SOURCES-1:0]     en_reg, en_next;
    logic [NUM_SOURCES-1:0]     pend_reg, pend_next;
    logic [NUM_SOURCES-1:0]     insv_reg, insv_next;
    logic [pic_pkg::PRIO_W-1:0] thr_reg, thr_next;

    logic [pic_pkg::ID_W-1:0]   best_id;
    logic                       aligned;
    logic [pic_pkg::ADDR_W-3:0] word;
    logic                       prio_hit;
    logic                       src_ok;
    logic [pic_pkg::ID_W-1:0]   cid;
    logic                       cid_ok;

    pic_arbiter #(
        .NUM_SOURCES (NUM_SOURCES)
    ) u_arbiter (
        .cand      (pend_reg & en_reg & SrcMask),
        .prio      (prio_reg),
        .threshold (thr_reg),
        .best_id   (best_id),
        .any       (irq_any)
    );

    assign aligned  = (item.address[1:0] == 2'b00);
    assign word     = item.address[pic_pkg::ADDR_W-1:2];
    assign prio_hit = (word != '0) && (word < (pic_pkg::ADDR_W-2)'(NUM_SOURCES));
    assign src_ok   = (item.source != '0)
                   && ({1'b0, item.source} < (pic_pkg::ID_W+1)'(NUM_SOURCES));
    assign cid      = item.write_data[pic_pkg::ID_W-1:0];
    assign cid_ok   = (item.write_data[pic_pkg::DATA_W-1:pic_pkg::ID_W] == '0)
                   && (cid != '0)
                   && ({1'b0, cid} < (pic_pkg::ID_W+1)'(NUM_SOURCES));

    always_comb
    begin
        prio_next = prio_reg;
        en_next   = en_reg;
        pend_next = pend_reg;
        insv_next = insv_reg;
        thr_next  = thr_reg;
        read_data = '0;
        case (item.kind)
            pic_pkg::KIND_RAISE:
            begin
                if (src_ok && !insv_reg[item.source[SrcW-1:0]])
                begin
                    pend_next[item.source[SrcW-1:0]] = 1'b1;
                end
            end
            pic_pkg::KIND_READ:
            begin
                if (aligned)
                begin
                    if (prio_hit)
                    begin
                        read_data = pic_pkg::DATA_W'(prio_reg[word[SrcW-1:0]]);
                    end
                    else if (item.address == pic_pkg::ENABLE_ADDR)
                    begin
                        read_data = pic_pkg::DATA_W'(en_reg);
                    end
                    else if (item.address == pic_pkg::THRESHOLD_ADDR)
                    begin
                        read_data = pic_pkg::DATA_W'(thr_reg);
                    end
                    else if (item.address == pic_pkg::CLAIM_ADDR)
                    begin
                        read_data = pic_pkg::DATA_W'(best_id);
                        if (best_id != '0)
                        begin
                            pend_next[best_id[SrcW-1:0]] = 1'b0;
                            insv_next[best_id[SrcW-1:0]] = 1'b1;
                        end
                    end
                end
            end
            pic_pkg::KIND_WRITE:
            begin
                if (aligned)
                begin
                    if (prio_hit)
                    begin
                        prio_next[word[SrcW-1:0]] = item.write_data[pic_pkg::PRIO_W-1:0];
                    end
                    else if (item.address == pic_pkg::ENABLE_ADDR)
                    begin
                        en_next = item.write_data[NUM_SOURCES-1:0] & SrcMask;
                    end
                    else if (item.address == pic_pkg::THRESHOLD_ADDR)
                    begin
                        thr_next = item.write_data[pic_pkg::PRIO_W-1:0];
                    end
                    else if (item.address == pic_pkg::CLAIM_ADDR)
                    begin
                        if (cid_ok && en_reg[cid[SrcW-1:0]])
                        begin
                            insv_next[cid[SrcW-1:0]] = 1'b0;
                        end
                    end
                end
            end
            default:
            begin
                read_data = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SOURCES; i++)
            begin
                prio_reg[i] <= '0;
            end
            en_reg   <= '0;
            pend_reg <= '0;
            insv_reg <= '0;
            thr_reg  <= '0;
        end
        else if (fire)
        begin
            prio_reg <= prio_next;
            en_reg   <= en_next;
            pend_reg <= pend_next;
            insv_reg <= insv_next;
            thr_reg  <= thr_next;
        end
    end

    assign pending    = pend_reg;
    assign in_service = insv_reg;

endmodule

/* rtl/core/platform_interrupt_controller.sv */
// Single-context interrupt controller with up to 32 sources (source 0 reserved),
// 3-bit priorities, one enable word at 0x2000, a threshold at 0x200000 and the
// claim/complete register at 0x200004. Each input transfer is a source raise
// or a bus access (tuser selects which) and yields exactly one output transfer
// carrying the read data and the interrupt line as it stands after that item.
// One item per cycle is sustained while the output is accepted: an input register
// feeds a combinational claim arbiter (per-level priority masks, then lowest-id
// pick) and the state update, and an output register holds the result.
module platform_interrupt_controller #(
    parameter int NUM_SOURCES = pic_pkg::NUM_SOURCES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // kind
    input  logic [63:0] s_tdata,   // source, address, write_data, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // read_data, interrupt_line, zero pad
);

    logic                       in_valid_reg, in_valid_next;
    pic_pkg::item_t             item_reg, item_next;
    logic                       out_valid_reg, out_valid_next;
    logic [pic_pkg::DATA_W-1:0] rdata_reg, rdata_next;
    logic                       fire;
    logic [pic_pkg::DATA_W-1:0] read_data;
    logic                       irq_any;
    logic [NUM_SOURCES-1:0]     pending;
    logic [NUM_SOURCES-1:0]     in_service;

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    pic_regs #(
        .NUM_SOURCES (NUM_SOURCES)
    ) u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .item       (item_reg),
        .read_data  (read_data),
        .irq_any    (irq_any),
        .pending    (pending),
        .in_service (in_service)
    );

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        item_next      = item_reg;
        out_valid_next = out_valid_reg;
        rdata_next     = rdata_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next       = 1'b1;
            item_next.kind       = pic_pkg::kind_t'(s_tuser);
            item_next.source     = s_tdata[4:0];
            item_next.address    = s_tdata[26:5];
            item_next.write_data = s_tdata[58:27];
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
        if (fire)
        begin
            out_valid_next = 1'b1;
            rdata_next     = read_data;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        rdata_reg <= rdata_next;
    end

    // Hold: state only moves when a result is loaded, so the line tracks it.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, irq_any, rdata_reg};

    a_no_pend_in_service: assert property (@(posedge clk) disable iff (!rst_n)
        (pending & in_service) == '0)
        else $error("source both pending and in service");

    a_reserved_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !pending[0] && !in_service[0])
        else $error("reserved source active");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without output backpressure");

endmodule

/* verif/platform_interrupt_controller_test.sv */
`timescale 1ns / 1ps

class claim_scoreboard;
    bit [2:0]  prio [32];
    bit [31:0] enabled;
    bit [31:0] pending;
    bit [31:0] in_service;
    bit [2:0]  threshold;
    bit [32:0] expected_q [$];   // {interrupt_line, read_data}
    int        mismatches;
    int        transfers;
    int        results;
    int        grants;
    int        irq_high;

    function bit [4:0] best_id();
        bit [4:0] id;
        bit [2:0] top;
        int       i;
        id = 0;
        top = threshold;
        for (i = 1; i < 32; i++)
        begin
            if (pending[i] && enabled[i] && prio[i] > top)
            begin
                id = 5'(i);
                top = prio[i];
            end
        end
        return id;
    endfunction

    function bit [4:0] pick_in_service();
        bit [4:0] ids [$];
        int       i;
        for (i = 1; i < 32; i++)
        begin
            if (in_service[i])
                ids.push_back(5'(i));
        end
        if (ids.size() == 0)
            return 5'($urandom_range(1, 31));
        return ids[$urandom_range(0, ids.size() - 1)];
    endfunction

    function void note_transfer(pic_pkg::kind_t kind, bit [4:0] src, bit [21:0] addr,
                                bit [31:0] wdata);
        bit [31:0] rdata;
        bit [4:0]  id;
        bit        aligned;
        bit        prio_reg;
        rdata = 0;
        aligned = addr[1:0] == 2'b00;
        prio_reg = aligned && addr[21:7] == 0 && addr[6:2] != 0;
        transfers++;
        case (kind)
            pic_pkg::KIND_RAISE:
            begin
                if (src != 0 && !in_service[src])
                    pending[src] = 1'b1;
            end
            pic_pkg::KIND_READ:
            begin
                if (prio_reg)
                    rdata = 32'(prio[addr[6:2]]);
                else if (addr == pic_pkg::ENABLE_ADDR)
                    rdata = enabled;
                else if (addr == pic_pkg::THRESHOLD_ADDR)
                    rdata = 32'(threshold);
                else if (addr == pic_pkg::CLAIM_ADDR)
                begin
                    id = best_id();
                    if (id != 0)
                    begin
                        pending[id] = 1'b0;
                        in_service[id] = 1'b1;
                        grants++;
                    end
                    rdata = 32'(id);
                end
            end
            pic_pkg::KIND_WRITE:
            begin
                if (prio_reg)
                    prio[addr[6:2]] = wdata[2:0];
                else if (addr == pic_pkg::ENABLE_ADDR)
                    enabled = wdata & 32'hFFFF_FFFE;
                else if (addr == pic_pkg::THRESHOLD_ADDR)
                    threshold = wdata[2:0];
                else if (addr == pic_pkg::CLAIM_ADDR)
                begin
                    if (wdata < 32 && wdata != 0 && enabled[wdata[4:0]])
                        in_service[wdata[4:0]] = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        expected_q.push_back({best_id() != 0, rdata});
    endfunction

    function void report(string what, bit [32:0] want, bit [32:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH %s: expected irq=%0b data=%08h, actual irq=%0b data=%08h",
                     what, want[32], want[31:0], got[32], got[31:0]);
    endfunction

    function void check_result(bit [31:0] rdata, bit irq);
        bit [32:0] want;
        results++;
        irq_high += irq;
        if (expected_q.size() == 0)
        begin
            report("unexpected transfer", 33'h0, {irq, rdata});
            return;
        end
        want = expected_q.pop_front();
        if (want[31:0] != rdata)
            report("read_data", want, {irq, rdata});
        if (want[32] != irq)
            report("interrupt_line", want, {irq, rdata});
    endfunction
endclass

module platform_interrupt_controller_test;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_CYCLES = 10;
    localparam int PHASE_ITEMS  = 410;
    localparam int HOLD_CYCLES  = 300;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [1:0]  s_tuser;    // kind
    logic [63:0] s_tdata;    // source, address, write_data, zero pad
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;    // read_data, interrupt_line, zero pad

    claim_scoreboard board = new;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_requests;
    int holds_seen;
    int hold_cycles;
    int cycle_count;

    platform_interrupt_controller dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                board.check_result(m_tdata[31:0], m_tdata[32]);
            if (s_tvalid && s_tready)
                board.note_transfer(pic_pkg::kind_t'(s_tuser), s_tdata[4:0], s_tdata[26:5],
                                    s_tdata[58:27]);
        end
    end

    // hold off during a requested stretch, otherwise stall at random
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (holds_seen != hold_requests)
        begin
            holds_seen = hold_requests;
            hold_cycles = HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            m_tready <= 1'b0;
            hold_cycles--;
        end
        else
            m_tready <= $urandom_range(99) >= recv_idle_pct;
    end

    task automatic send_item(pic_pkg::kind_t kind, bit [4:0] src, bit [21:0] addr,
                             bit [31:0] wdata);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {5'b0, wdata, addr, src};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.expected_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic random_item();
        int        pick;
        bit [4:0]  id;
        bit [31:0] d;
        bit [21:0] a;
        pick = $urandom_range(99);
        id = 5'($urandom_range(31));
        if (pick < 30)
            send_item(pic_pkg::KIND_RAISE, id, 22'($urandom), $urandom);
        else if (pick < 55)
            send_item(pic_pkg::KIND_READ, id, pic_pkg::CLAIM_ADDR, $urandom);
        else if (pick < 70)
        begin
            d = ($urandom_range(9) == 0) ? $urandom : 32'(board.pick_in_service());
            send_item(pic_pkg::KIND_WRITE, id, pic_pkg::CLAIM_ADDR, d);
        end
        else if (pick < 80)
            send_item(pic_pkg::KIND_WRITE, id, 22'({id, 2'b00}), $urandom);
        else if (pick < 85)
            send_item(pic_pkg::KIND_WRITE, id, pic_pkg::ENABLE_ADDR, $urandom | $urandom);
        else if (pick < 89)
        begin
            d = $urandom;
            if ($urandom_range(3) != 0)
                d[2:0] = 3'($urandom_range(0, 3));
            send_item(pic_pkg::KIND_WRITE, id, pic_pkg::THRESHOLD_ADDR, d);
        end
        else if (pick < 96)
        begin
            case ($urandom_range(2))
                0: a = 22'({id, 2'b00});
                1: a = pic_pkg::ENABLE_ADDR;
                default: a = pic_pkg::THRESHOLD_ADDR;
            endcase
            send_item(pic_pkg::KIND_READ, id, a, $urandom);
        end
        else
        begin
            if ($urandom_range(1))
                a = 22'($urandom);
            else
                a = pic_pkg::CLAIM_ADDR + 22'($urandom_range(1, 3));
            send_item($urandom_range(1) ? pic_pkg::KIND_READ : pic_pkg::KIND_WRITE,
                      id, a, $urandom);
        end
    endtask

    initial
    begin
        int phase;
        int n;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = '0;
        s_tdata = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_item(pic_pkg::KIND_READ,  5'd0, pic_pkg::CLAIM_ADDR,     32'h0);
        send_item(pic_pkg::KIND_READ,  5'd0, 22'h000000,              32'hFFFF_FFFF);
        send_item(pic_pkg::KIND_WRITE, 5'd0, 22'h000000,              32'hFFFF_FFFF);
        send_item(pic_pkg::KIND_WRITE, 5'd0, 22'h000004,              32'hFFFF_FFFF);
        send_item(pic_pkg::KIND_WRITE, 5'd0, 22'h00007C,              32'h0000_0005);
        send_item(pic_pkg::KIND_WRITE, 5'd0, 22'h000014,              32'h0000_0007);
        send_item(pic_pkg::KIND_WRITE, 5'd0, 22'h00000C,              32'h0000_0002);
        send_item(pic_pkg::KIND_WRITE, 5'd0, pic_pkg::ENABLE_ADDR,    32'hFFFF_FFFF);
        send_item(pic_pkg::KIND_WRITE, 5'd0, pic_pkg::THRESHOLD_ADDR, 32'hFFFF_FFFA);
        send_item(pic_pkg::KIND_READ,  5'd0, pic_pkg::THRESHOLD_ADDR, 32'h0);
        send_item(pic_pkg::KIND_READ,  5'd0, pic_pkg::ENABLE_ADDR,    32'h0);
        send_item(pic_pkg::KIND_RAISE, 5'd0, 22'h3FFFFF,              32'hFFFF_FFFF);
        send_item(pic_pkg::KIND_RAISE, 5'd3, 22'h0,                   32'h0);
        send_item(pic_pkg::KIND_RAISE, 5'd5, 22'h0,                   32'h0);
        send_item(pic_pkg::KIND_RAISE, 5'd1, 22'h0,                   32'h0);
        send_item(pic_pkg::KIND_RAISE, 5'd31, 22'h0,                  32'h0);
        send_item(pic_pkg::KIND_READ,  5'd0, pic_pkg::CLAIM_ADDR,     32'h0);
        send_item(pic_pkg::KIND_RAISE, 5'd1, 22'h0,                   32'h0);
        send_item(pic_pkg::KIND_READ,  5'd0, pic_pkg::CLAIM_ADDR,     32'h0);
        send_item(pic_pkg::KIND_WRITE, 5'd0, pic_pkg::CLAIM_ADDR,     32'h0000_0001);
        send_item(pic_pkg::KIND_WRITE, 5'd0, pic_pkg::CLAIM_ADDR,     32'hFFFF_FFFF);
        send_item(pic_pkg::KIND_READ,  5'd0, 22'h002001,              32'h0);
        send_item(pic_pkg::KIND_WRITE, 5'd0, 22'h200006,              32'h0000_0005);
        send_item(pic_pkg::KIND_READ,  5'd0, 22'h3FFFFC,              32'h0);
        send_item(pic_pkg::KIND_READ,  5'd0, 22'h00007C,              32'h0);
        send_item(pic_pkg::kind_t'(2'd3), 5'd7, pic_pkg::CLAIM_ADDR,  32'h0000_0005);
        send_item(pic_pkg::KIND_WRITE, 5'd0, pic_pkg::ENABLE_ADDR,    32'h0);
        send_item(pic_pkg::KIND_WRITE, 5'd0, pic_pkg::CLAIM_ADDR,     32'h0000_0005);
        drain();

        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 37; recv_idle_pct = 46; end
                1: begin send_idle_pct = 46; recv_idle_pct = 37; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 2 && phase != 1)
                    hold_requests++;
                random_item();
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.expected_q.size() != 0)
        begin
            $display("%0d expected transfers never arrived", board.expected_q.size());
            board.mismatches += board.expected_q.size();
        end
        $display("covered %0d input transfers and %0d results, %0d claims granted",
                 board.transfers, board.results, board.grants);
        $display("interrupt line high on %0d results, %0d mismatches",
                 board.irq_high, board.mismatches);
        if (board.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

/* platform_interrupt_controller.f */
rtl/core/pic_pkg.sv
rtl/core/pic_arbiter.sv
rtl/core/pic_regs.sv
rtl/core/platform_interrupt_controller.sv
verif/platform_interrupt_controller_test.sv
